### hdl/substring_replace_first_defines.svh
// assertion macros of the substring rewriter top level
// expects aclk and aresetn in the scope where a macro is used
`ifndef SUBSTRING_REPLACE_FIRST_DEFINES_SVH
`define SUBSTRING_REPLACE_FIRST_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define SRF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent at an edge implies consequent at the next edge
`define SRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent at the same edge
`define SRF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define SRF_ASSERT_ALWAYS(label, cond, msg)
`define SRF_ASSERT_NEXT(label, ante, cons, msg)
`define SRF_ASSERT_SAME(label, ante, cons, msg)

`endif

`endif

### hdl/srf_pkg.sv
// types and constants of the substring rewriter
// used by the window cells, the emit cells and the top level
`timescale 1ns / 1ps

package srf_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int REG_BYTES = 8;
    localparam int CFG_W     = BYTE_W * REG_BYTES;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

    // control broadcast to every window cell
    typedef struct packed {
        logic              adv;
        logic              pop;
        logic [BYTE_W-1:0] text_byte;
    } win_ctrl_t;

    // control broadcast to every emit cell
    typedef struct packed {
        logic load;
        logic shift;
        logic skip;
    } emit_ctrl_t;

endpackage

### hdl/srf_win_cell.sv
// one byte of the match window, with its pattern compare
// depends on srf_pkg
`timescale 1ns / 1ps

module srf_win_cell import srf_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 4
) (
    input  logic              aclk,
    input  win_ctrl_t         ctrl,
    input  logic [CNT_W-1:0]  fill,
    input  logic [CNT_W-1:0]  l_act,
    input  logic [BYTE_W-1:0] pat_byte,
    input  logic [BYTE_W-1:0] nbr_in,
    output logic [BYTE_W-1:0] w_out,
    output logic              eq_out
);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    // window contents after the incoming byte is appended
    assign w_out  = (fill == CNT_W'(IDX)) ? ctrl.text_byte : data_reg;
    // cells past the pattern length always agree
    assign eq_out = (CNT_W'(IDX) >= l_act) || (w_out == pat_byte);

    assign data_next = ctrl.pop ? nbr_in : w_out;

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            data_reg <= data_next;
        end
    end

endmodule

### hdl/srf_emit_cell.sv
// one slot of the result burst queue, shifts toward the output register
// depends on srf_pkg
`timescale 1ns / 1ps

module srf_emit_cell import srf_pkg::*; (
    input  logic              aclk,
    input  emit_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] src_cur,
    input  logic [BYTE_W-1:0] src_nxt,
    input  logic [BYTE_W-1:0] nbr_in,
    output logic [BYTE_W-1:0] q_out
);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    // on skip the first result went straight to the output register
    assign data_next = ctrl.load ? (ctrl.skip ? src_nxt : src_cur) : nbr_in;
    assign q_out     = data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load || ctrl.shift) begin
            data_reg <= data_next;
        end
    end

endmodule

### hdl/substring_replace_first.sv
// Byte stream rewriter: replaces the first occurrence of the configured pattern in each text
// (ended by final_byte) with the configured replacement. The first result of a byte is
// registered in the output register at the transfer of that byte if that register is free.
// A byte that yields one result or none is taken every cycle while the output flows. A byte
// that yields n results (a replacement burst or the flush of the window on the final byte)
// sends its first result straight to the output register when that register is free and
// parks the rest in the burst queue of emit cells, which drains one byte per result
// transfer; s_ready stays low until that queue is empty.
// Configure only while idle.
// depends on srf_pkg, srf_win_cell, srf_emit_cell and substring_replace_first_defines.svh
`timescale 1ns / 1ps
`include "substring_replace_first_defines.svh"

module substring_replace_first import srf_pkg::*; #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_text_byte,
    input  logic                 s_final_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_result_byte,
    output logic                 m_run_last,
    output logic                 m_text_end
);

    localparam int WIN_CAP  = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int REP_CAP  = (MAX_REPLACEMENT < REG_BYTES) ? MAX_REPLACEMENT : REG_BYTES;
    localparam int EMIT_CAP = (WIN_CAP > REP_CAP) ? WIN_CAP : REP_CAP;
    localparam int CNT_W    = $clog2(WIN_CAP + 1);
    localparam int RL_W     = $clog2(REP_CAP + 1);
    localparam int EMIT_W   = $clog2(EMIT_CAP + 1);

    // configuration
    logic [CFG_W-1:0] pat_reg;
    logic [LEN_W-1:0] plen_reg;
    logic [CFG_W-1:0] rep_reg;
    logic [LEN_W-1:0] rlen_reg;

    // window control
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic [CNT_W-1:0] act_reg;
    logic             done_reg,   done_next;

    // burst queue and output register
    logic [EMIT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic              emit_end_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_run_last_reg;
    logic              out_text_end_reg;

    logic              accept;
    logic              out_free;
    logic              direct;
    logic              shift_q;
    logic [CNT_W-1:0]  plen_sat;
    logic [RL_W-1:0]   rl_sat;
    logic [CNT_W-1:0]  l_now;
    logic [CNT_W-1:0]  fill_inc;
    logic              full;
    logic              hit;
    logic [EMIT_W-1:0] n_items;

    win_ctrl_t  win_ctrl;
    emit_ctrl_t emit_ctrl;

    logic [BYTE_W-1:0] win_w     [WIN_CAP+1];
    logic [WIN_CAP-1:0] win_eq;
    logic [BYTE_W-1:0] list_byte [EMIT_CAP+1];
    logic [BYTE_W-1:0] emit_q    [EMIT_CAP+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg  <= '0;
            plen_reg <= '0;
            rep_reg  <= '0;
            rlen_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_BYTES:      pat_reg  <= cfg_data;
                CFG_PATTERN_LENGTH:     plen_reg <= cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  rep_reg  <= cfg_data;
                CFG_REPLACEMENT_LENGTH: rlen_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign plen_sat = (plen_reg > LEN_W'(WIN_CAP)) ? CNT_W'(WIN_CAP) : plen_reg[CNT_W-1:0];
    assign rl_sat   = (rlen_reg > LEN_W'(REP_CAP)) ? RL_W'(REP_CAP) : rlen_reg[RL_W-1:0];

    assign s_ready  = (emit_cnt_reg == '0);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // pattern length is latched by each byte accepted while the window is empty
    assign l_now    = (fill_reg == '0) ? plen_sat : act_reg;
    assign fill_inc = fill_reg + 1'b1;
    assign full     = (l_now != '0) && (fill_inc == l_now);
    assign hit      = full && !done_reg && (&win_eq);

    always_comb begin
        if (l_now == '0) begin
            n_items = EMIT_W'(1);
        end else if (hit) begin
            n_items = EMIT_W'(rl_sat);
        end else if (s_final_byte) begin
            n_items = EMIT_W'(fill_inc);
        end else if (full) begin
            n_items = EMIT_W'(1);
        end else begin
            n_items = '0;
        end
    end

    always_comb begin
        if ((l_now == '0) || s_final_byte || hit) begin
            fill_next = '0;
        end else if (full) begin
            fill_next = l_now - 1'b1;
        end else begin
            fill_next = fill_inc;
        end
        if (s_final_byte) begin
            done_next = 1'b0;
        end else begin
            done_next = done_reg || hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            act_reg  <= '0;
            done_reg <= 1'b0;
        end else if (accept) begin
            fill_reg <= fill_next;
            done_reg <= done_next;
            if (fill_reg == '0) begin
                act_reg <= plen_sat;
            end
        end
    end

    // window cells
    assign win_ctrl.adv       = accept;
    assign win_ctrl.pop       = full && !hit;
    assign win_ctrl.text_byte = s_text_byte;
    assign win_w[WIN_CAP]     = '0;

    for (genvar i = 0; i < WIN_CAP; i++) begin : g_win
        srf_win_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (win_ctrl),
            .fill     (fill_reg),
            .l_act    (l_now),
            .pat_byte (pat_reg[BYTE_W*i +: BYTE_W]),
            .nbr_in   (win_w[i+1]),
            .w_out    (win_w[i]),
            .eq_out   (win_eq[i])
        );
    end

    // results of one byte: replacement bytes or window bytes, oldest first
    for (genvar i = 0; i <= EMIT_CAP; i++) begin : g_list
        logic [BYTE_W-1:0] rep_b;
        logic [BYTE_W-1:0] win_b;
        if (i < REP_CAP) begin : g_rep
            assign rep_b = rep_reg[BYTE_W*i +: BYTE_W];
        end else begin : g_rep_pad
            assign rep_b = '0;
        end
        if (i < WIN_CAP) begin : g_wb
            assign win_b = win_w[i];
        end else begin : g_wb_pad
            assign win_b = '0;
        end
        assign list_byte[i] = hit ? rep_b : win_b;
    end

    // burst queue
    assign direct  = accept && out_free && (n_items != '0);
    assign shift_q = (emit_cnt_reg != '0) && out_free;

    assign emit_ctrl.load  = accept;
    assign emit_ctrl.shift = shift_q;
    assign emit_ctrl.skip  = out_free;
    assign emit_q[EMIT_CAP] = '0;

    for (genvar i = 0; i < EMIT_CAP; i++) begin : g_emit
        srf_emit_cell u_cell (
            .aclk    (aclk),
            .ctrl    (emit_ctrl),
            .src_cur (list_byte[i]),
            .src_nxt (list_byte[i+1]),
            .nbr_in  (emit_q[i+1]),
            .q_out   (emit_q[i])
        );
    end

    always_comb begin
        if (accept) begin
            emit_cnt_next = direct ? (n_items - 1'b1) : n_items;
        end else if (shift_q) begin
            emit_cnt_next = emit_cnt_reg - 1'b1;
        end else begin
            emit_cnt_next = emit_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_cnt_reg  <= '0;
            emit_end_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            emit_cnt_reg <= emit_cnt_next;
            if (accept) begin
                emit_end_reg <= s_final_byte;
            end
            if (direct || shift_q) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (direct) begin
            out_byte_reg     <= list_byte[0];
            out_run_last_reg <= (n_items == EMIT_W'(1));
            out_text_end_reg <= s_final_byte && (n_items == EMIT_W'(1));
        end else if (shift_q) begin
            out_byte_reg     <= emit_q[0];
            out_run_last_reg <= (emit_cnt_reg == EMIT_W'(1));
            out_text_end_reg <= emit_end_reg && (emit_cnt_reg == EMIT_W'(1));
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_byte = out_byte_reg;
    assign m_run_last    = out_run_last_reg;
    assign m_text_end    = out_text_end_reg;

    `SRF_ASSERT_SAME(a_fill_below_len, fill_reg != '0, fill_reg < act_reg, "window overfull")
    `SRF_ASSERT_SAME(a_queue_behind_out, emit_cnt_reg != '0, out_valid_reg, "output idle")
    `SRF_ASSERT_NEXT(a_final_clears, accept && s_final_byte, ~|{fill_reg, done_reg}, "not cleared")
    `SRF_ASSERT_NEXT(a_done_on_hit, !done_reg && !(accept && hit), !done_reg, "spurious flag")
    `SRF_ASSERT_SAME(a_end_is_last, m_valid && m_text_end, m_run_last, "text end not last")

endmodule

### tb/testbench.sv
// self-checking testbench for substring_replace_first: directed texts, then random texts
// checked against a byte-level rewrite predictor; needs srf_pkg and the rewriter rtl
`timescale 1ns / 1ps

module testbench import srf_pkg::*; ();

    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_ITEMS  = 220;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_last;
        logic              text_end;
    } out_beat_t;

    // keeps its own copy of the window state and the registers
    class rewrite_scoreboard;
        logic [CFG_W-1:0]  pat_bytes;
        logic [CFG_W-1:0]  rep_bytes;
        logic [LEN_W-1:0]  pat_len;
        logic [LEN_W-1:0]  rep_len;
        logic [BYTE_W-1:0] window [REG_BYTES];
        int unsigned       fill;
        int unsigned       active_len;
        bit                replaced;
        out_beat_t         step_beats [$];
        out_beat_t         expected_beats [$];
        int                errors;

        function new();
            pat_bytes  = '0;
            rep_bytes  = '0;
            pat_len    = '0;
            rep_len    = '0;
            foreach (window[i]) window[i] = '0;
            fill       = 0;
            active_len = 0;
            replaced   = 0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_PATTERN_BYTES:      pat_bytes = val;
                CFG_PATTERN_LENGTH:     pat_len   = val[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  rep_bytes = val;
                CFG_REPLACEMENT_LENGTH: rep_len   = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void push_beat(logic [BYTE_W-1:0] b);
            out_beat_t beat;
            beat.data     = b;
            beat.run_last = 1'b0;
            beat.text_end = 1'b0;
            step_beats.push_back(beat);
        endfunction

        function void pop_oldest();
            push_beat(window[0]);
            for (int i = 1; i < fill; i++) window[i-1] = window[i];
            fill--;
        endfunction

        // expected results for one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b, logic fin);
            int unsigned rl;
            bit          hit;
            int          last;
            step_beats.delete();
            // pattern length only takes effect with an empty window
            if (fill == 0) active_len = (pat_len > REG_BYTES) ? REG_BYTES : pat_len;
            if (active_len == 0) begin
                push_beat(b);
            end else begin
                if (fill < REG_BYTES) begin
                    window[fill] = b;
                    fill++;
                end
                if (fill >= active_len) begin
                    hit = !replaced;
                    for (int i = 0; i < active_len; i++)
                        if (window[i] != pat_bytes[8*i +: 8]) hit = 0;
                    if (hit) begin
                        rl = (rep_len > REG_BYTES) ? REG_BYTES : rep_len;
                        for (int i = 0; i < rl; i++) push_beat(rep_bytes[8*i +: 8]);
                        fill     = 0;
                        replaced = 1;
                    end else begin
                        pop_oldest();
                    end
                end
                if (fin)
                    while (fill > 0) pop_oldest();
            end
            if (fin) begin
                fill     = 0;
                replaced = 0;
            end
            if (step_beats.size() > 0) begin
                last = step_beats.size() - 1;
                step_beats[last].run_last = 1'b1;
                step_beats[last].text_end = fin;
            end
            foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
        endfunction

        function void check_result(logic [BYTE_W-1:0] b, logic rl, logic te);
            out_beat_t exp_beat;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result byte, expected none, got %02h", $time, b);
                errors++;
                return;
            end
            exp_beat = expected_beats.pop_front();
            if (b !== exp_beat.data) begin
                $display("%0t: result_byte expected %02h, got %02h", $time, exp_beat.data, b);
                errors++;
            end
            if (rl !== exp_beat.run_last) begin
                $display("%0t: run_last expected %0b, got %0b", $time, exp_beat.run_last, rl);
                errors++;
            end
            if (te !== exp_beat.text_end) begin
                $display("%0t: text_end expected %0b, got %0b", $time, exp_beat.text_end, te);
                errors++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    cfg_index_t        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_text_byte;
    logic              s_final_byte;
    logic              m_valid;
    logic              m_ready;
    logic [BYTE_W-1:0] m_result_byte;
    logic              m_run_last;
    logic              m_text_end;

    rewrite_scoreboard sb;
    bit                tx_gaps = 1;
    bit                rx_gaps = 1;
    int                items_sent = 0;
    logic [CFG_W-1:0]  cur_pat = '0;
    int                cur_plen = 0;

    substring_replace_first dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .s_final_byte (s_final_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_byte(m_result_byte),
        .m_run_last   (m_run_last),
        .m_text_end   (m_text_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stall before each transfer
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = rx_gaps ? $urandom_range(0, 13) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            sb.check_result(m_result_byte, m_run_last, m_text_end);
        end
    end

    // valid stays high across back-to-back writes; caller drops it
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input logic [CFG_W-1:0] pat, input int plen,
                             input logic [CFG_W-1:0] rep, input int rlen);
        cur_pat  = pat;
        cur_plen = plen;
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_PATTERN_LENGTH, CFG_W'(plen));
        write_reg(CFG_REPLACEMENT_BYTES, rep);
        write_reg(CFG_REPLACEMENT_LENGTH, CFG_W'(rlen));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_text_byte  <= b;
        s_final_byte <= fin;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_byte(b, fin);
        items_sent++;
    endtask

    // hold the input until every pending result has come out
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly pattern pieces and pattern bytes, some noise
    task automatic send_text(input int len, input bit finish);
        logic [BYTE_W-1:0] text_q [$];
        int                r;
        int                k;
        int                plen_eff;
        plen_eff = (cur_plen > REG_BYTES) ? REG_BYTES : cur_plen;
        while (text_q.size() < len) begin
            r = $urandom_range(0, 9);
            if (r < 3 && plen_eff > 0) begin
                for (int i = 0; i < plen_eff; i++) text_q.push_back(cur_pat[8*i +: 8]);
            end else if (r < 5 && plen_eff > 1) begin
                k = $urandom_range(1, plen_eff - 1);
                for (int i = 0; i < k; i++) text_q.push_back(cur_pat[8*i +: 8]);
            end else if (r < 9) begin
                k = $urandom_range(0, REG_BYTES - 1);
                text_q.push_back(cur_pat[8*k +: 8]);
            end else begin
                text_q.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end
        foreach (text_q[i]) send_byte(text_q[i], finish && (i == text_q.size() - 1));
    endtask

    task automatic random_setup();
        logic [BYTE_W-1:0] sym [3];
        logic [CFG_W-1:0]  pat;
        logic [CFG_W-1:0]  rep;
        int                plen;
        int                rlen;
        int                r;
        foreach (sym[i]) sym[i] = BYTE_W'($urandom_range(0, 255));
        for (int i = 0; i < REG_BYTES; i++) pat[8*i +: 8] = sym[$urandom_range(0, 2)];
        r = $urandom_range(0, 9);
        if (r == 0) pat = '0;
        else if (r == 1) pat = '1;
        rep = {$urandom, $urandom};
        r = $urandom_range(0, 9);
        if (r == 0) rep = '0;
        else if (r == 1) rep = '1;
        r = $urandom_range(0, 19);
        if (r == 0) plen = 0;
        else if (r < 3) plen = $urandom_range(9, 15);
        else if (r < 6) plen = REG_BYTES;
        else plen = $urandom_range(1, 7);
        r = $urandom_range(0, 19);
        if (r < 3) rlen = 0;
        else if (r < 5) rlen = $urandom_range(9, 15);
        else if (r < 8) rlen = REG_BYTES;
        else rlen = $urandom_range(1, 7);
        configure(pat, plen, rep, rlen);
    endtask

    initial begin
        int goal;
        aresetn      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_PATTERN_BYTES;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_text_byte  <= '0;
        s_final_byte <= 1'b0;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pass through with the reset configuration
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);

        // only the first of two occurrences is replaced
        drain();
        configure(64'hffff_ffff_ff43_4241, 3, 64'h0000_0000_0000_5958, 2);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b1);

        // deleted match on the final byte leaves the final step empty
        drain();
        write_reg(CFG_REPLACEMENT_LENGTH, CFG_W'(0));
        cfg_valid <= 1'b0;
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b1);

        // oversized lengths saturate to eight
        drain();
        configure(64'h0706_0504_0302_0100, 15, '1, 12);
        for (int i = 0; i < REG_BYTES; i++) send_byte(BYTE_W'(i), i == REG_BYTES - 1);

        // length written while the window holds a byte applies only once it empties
        drain();
        configure(64'h0000_0000_0000_4241, 2, 64'h0000_0000_0000_005a, 1);
        send_byte(8'h41, 1'b0);
        drain();
        write_reg(CFG_PATTERN_LENGTH, CFG_W'(1));
        cfg_valid <= 1'b0;
        cur_plen = 1;
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b1);

        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            drain();
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            random_setup();
            repeat ($urandom_range(1, 4))
                send_text($urandom_range(1, 24), $urandom_range(0, 4) != 0);
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
